@@ rtl/stream_pattern_replace_macros.svh @@
// Assertion macros used by the stream find-and-replace port checker.
`ifndef STREAM_PATTERN_REPLACE_MACROS_SVH
`define STREAM_PATTERN_REPLACE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define SPR_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/spr_pkg.sv @@
// Package: types and constants of the stream find-and-replace block.
`timescale 1ns / 1ps
package spr_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 64;
    localparam int BIDX_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_CAP   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } spr_cfg_idx_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic insert;
        logic shift;
        logic active;
    } spr_cell_ctl_t;

    // Work still owed for the request in flight.
    typedef struct packed {
        logic [1:0]        pops;
        logic [LEN_W-1:0]  rep_rem;
        logic [BIDX_W-1:0] rep_idx;
        logic              flush;
    } spr_plan_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              out_last;
    } spr_result_t;

endpackage

@@ rtl/spr_if.sv @@
// Interfaces: input byte channel and result channel.
`timescale 1ns / 1ps
interface spr_in_if;
    logic                      valid;
    logic                      ready;
    logic [spr_pkg::BYTE_W-1:0] in_byte;
    logic                      in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface spr_out_if;
    logic                      valid;
    logic                      ready;
    logic [spr_pkg::BYTE_W-1:0] out_byte;
    logic                      has_byte;
    logic                      out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

@@ rtl/spr_cell.sv @@
// One window cell: holds a byte, shifts toward the head, compares to its pattern byte.
`timescale 1ns / 1ps
module spr_cell (
    input  logic                          clk,
    input  spr_pkg::spr_cell_ctl_t        ctl,
    input  logic [spr_pkg::BYTE_W-1:0]    in_byte,
    input  logic [spr_pkg::BYTE_W-1:0]    nb_view,
    input  logic [spr_pkg::BYTE_W-1:0]    pat_byte,
    input  logic                          match_in,
    output logic [spr_pkg::BYTE_W-1:0]    view,
    output logic                          match_out
);
    import spr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // The incoming byte lands here in the same cycle it is seen.
    assign view      = ctl.insert ? in_byte : byte_reg;
    assign match_out = match_in && (!ctl.active || (view == pat_byte));
    assign byte_next = ctl.shift ? nb_view : view;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

@@ rtl/spr_out_buf.sv @@
// Two-entry result buffer that decouples the sequencer from the result channel.
`timescale 1ns / 1ps
module spr_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  spr_pkg::spr_result_t push_data,
    output logic                 full,
    spr_out_if.source            result
);
    import spr_pkg::*;

    spr_result_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        pop;

    assign pop             = result.valid && result.ready;
    assign result.valid    = (fill_reg != 2'd0);
    assign result.out_byte = entry_reg[rd_ptr_reg].out_byte;
    assign result.has_byte = entry_reg[rd_ptr_reg].has_byte;
    assign result.out_last = entry_reg[rd_ptr_reg].out_last;
    assign full            = (fill_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ rtl/stream_pattern_replace.sv @@
// Top level: streaming find-and-replace over a byte string.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------
//   text     | in  | valid/ready   | in_byte[7:0], in_last
//   result   | out | valid/ready   | out_byte[7:0], has_byte, out_last
//   cfg      | in  | cfg_we        | cfg_index[1:0], cfg_data[63:0]
//
// The sequencer writes the results of a request into the result buffer, one
// per cycle while the buffer has room; under the same condition a plain byte
// (at most one result) goes through at one request per cycle.
// Reset clears the window count, the pending work and the registers
// (pattern length 1); window bytes are never read before they are written.
// A stalled result channel fills the two-entry buffer, then holds text.ready low once a request owes results.
`timescale 1ns / 1ps
module stream_pattern_replace #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spr_pkg::CFG_W-1:0]       cfg_data,
    spr_in_if.sink                          text,
    spr_out_if.source                       result
);
    import spr_pkg::*;

    // The window never holds more bytes than the longest usable pattern.
    localparam int PAT_CAP   = (MAX_PATTERN < LEN_CAP) ? MAX_PATTERN : LEN_CAP;
    localparam int REP_CAP   = (MAX_REPLACEMENT < LEN_CAP) ? MAX_REPLACEMENT : LEN_CAP;
    localparam int WIN_DEPTH = PAT_CAP;

    // Configuration registers.
    logic [CFG_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] replacement_bytes_reg;
    logic [LEN_W-1:0] replacement_length_reg;

    // Sequencer state.
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    spr_plan_t        plan_reg;
    spr_plan_t        plan_next;

    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    logic             busy;
    logic             acc;
    logic             buf_full;
    logic             shift;
    logic             match;
    logic             push;
    spr_result_t      push_data;

    logic [BYTE_W-1:0] view [WIN_DEPTH];
    logic              chain [WIN_DEPTH+1];
    spr_cell_ctl_t     cell_ctl [WIN_DEPTH];

    // ---------------------------------------------------------------------
    // Configuration writes; lengths are cut to what the hardware supports.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= LEN_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (spr_cfg_idx_t'(cfg_index))
                CFG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign plen = (pattern_length_reg > LEN_W'(PAT_CAP)) ? LEN_W'(PAT_CAP)
                                                         : pattern_length_reg;
    assign rlen = (replacement_length_reg > LEN_W'(REP_CAP)) ? LEN_W'(REP_CAP)
                                                             : replacement_length_reg;

    // Take a new request only once every result of the last one is queued.
    assign busy       = (plan_reg.pops != 2'd0) || (plan_reg.rep_rem != '0) || plan_reg.flush;
    assign text.ready = !busy;
    assign acc        = text.valid && text.ready;

    // ---------------------------------------------------------------------
    // Window: a row of cells. The new byte lands at the fill position, a
    // pop moves every byte one cell toward the head, and the compare result
    // ripples along the row.
    // ---------------------------------------------------------------------
    assign chain[0] = 1'b1;
    assign match    = chain[WIN_DEPTH];

    for (genvar i = 0; i < WIN_DEPTH; i++)
    begin : g_cell
        logic [BYTE_W-1:0] nb_view;

        if (i == WIN_DEPTH - 1)
        begin : g_tail
            assign nb_view = '0;
        end
        else
        begin : g_body
            assign nb_view = view[i+1];
        end

        assign cell_ctl[i].insert = acc && (count_reg == LEN_W'(i));
        assign cell_ctl[i].shift  = shift;
        assign cell_ctl[i].active = (LEN_W'(i) < plen);

        spr_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[i]),
            .in_byte   (text.in_byte),
            .nb_view   (nb_view),
            .pat_byte  (pattern_bytes_reg[BYTE_W*i +: BYTE_W]),
            .match_in  (chain[i]),
            .view      (view[i]),
            .match_out (chain[i+1])
        );
    end

    // ---------------------------------------------------------------------
    // Sequencer: plan the work of a fresh request, then run one step of the
    // current plan per cycle while the result buffer has room.
    // Step order: pending pops, replacement bytes, flush pops, end marker.
    // ---------------------------------------------------------------------
    always_comb
    begin
        logic [LEN_W-1:0] c1;
        logic [LEN_W-1:0] excess;
        logic [LEN_W-1:0] count_cur;
        spr_plan_t        plan_cur;
        logic             do_pop;
        logic             do_rep;
        logic             do_mark;
        logic             can_emit;

        c1        = count_reg + LEN_W'(1);
        excess    = c1 - plen;
        count_cur = count_reg;
        plan_cur  = plan_reg;
        do_pop    = 1'b0;
        do_rep    = 1'b0;
        do_mark   = 1'b0;
        can_emit  = !buf_full;

        if (acc)
        begin
            plan_cur.pops    = 2'd0;
            plan_cur.rep_rem = '0;
            plan_cur.rep_idx = '0;
            plan_cur.flush   = text.in_last;
            count_cur        = c1;
            if (c1 > plen)
            begin
                // Window outgrew a shortened pattern: drop up to two bytes.
                plan_cur.pops = (excess > LEN_W'(1)) ? 2'd2 : 2'd1;
            end
            else if (c1 == plen)
            begin
                if (match)
                begin
                    plan_cur.rep_rem = rlen;
                    count_cur        = '0;
                end
                else
                begin
                    plan_cur.pops = 2'd1;
                end
            end
        end

        if (can_emit)
        begin
            if (plan_cur.pops != 2'd0)
            begin
                do_pop = 1'b1;
            end
            else if (plan_cur.rep_rem != '0)
            begin
                do_rep = 1'b1;
            end
            else if (plan_cur.flush)
            begin
                if (count_cur != '0)
                begin
                    do_pop = 1'b1;
                end
                else
                begin
                    do_mark = 1'b1;
                end
            end
        end

        plan_next  = plan_cur;
        count_next = count_cur - LEN_W'(do_pop);
        if (do_pop && (plan_cur.pops != 2'd0))
        begin
            plan_next.pops = plan_cur.pops - 2'd1;
        end
        if (do_rep)
        begin
            plan_next.rep_rem = plan_cur.rep_rem - LEN_W'(1);
            plan_next.rep_idx = plan_cur.rep_idx + BIDX_W'(1);
        end

        push               = do_pop || do_rep || do_mark;
        shift              = do_pop;
        push_data.has_byte = !do_mark;
        push_data.out_byte = do_pop ? view[0]
                           : do_rep ? replacement_bytes_reg[{plan_cur.rep_idx, 3'b000} +: BYTE_W]
                           : '0;
        // Mark the final result of the string and end the flush with it.
        push_data.out_last = plan_cur.flush && (plan_next.pops == 2'd0)
                          && (plan_next.rep_rem == '0) && (count_next == '0);
        if (push && push_data.out_last)
        begin
            plan_next.flush = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            plan_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            plan_reg  <= plan_next;
        end
    end

    spr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .result    (result)
    );

endmodule

@@ rtl/spr_checker.sv @@
// Checker on the top-level ports of the find-and-replace block, with its bind.
`timescale 1ns / 1ps
`include "stream_pattern_replace_macros.svh"
module spr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         text_valid,
    input logic                         text_ready,
    input logic                         text_in_last,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [spr_pkg::BYTE_W-1:0]   result_out_byte,
    input logic                         result_has_byte,
    input logic                         result_out_last
);
    import spr_pkg::*;

    // Strings whose final byte went in but whose final result has not come out.
    logic [2:0] open_reg;
    logic [2:0] open_next;

    always_comb
    begin
        open_next = open_reg
                  + {2'b00, text_valid && text_ready && text_in_last}
                  - {2'b00, result_valid && result_ready && result_out_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `SPR_ASSERT(a_marker_is_final, result_valid && !result_has_byte, result_out_last && (result_out_byte == '0), "bare marker not final or carries a byte")
    `SPR_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(result_out_byte) && $stable(result_has_byte) && $stable(result_out_last), "stalled result changed")
    `SPR_ASSERT(a_last_has_string, result_valid && result_ready && result_out_last, open_reg != 3'd0, "end of string without a final input byte")
    `SPR_ASSERT(a_stall_has_output, !text_ready, result_valid, "input held off with no result waiting")

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .text_valid      (text.valid),
    .text_ready      (text.ready),
    .text_in_last    (text.in_last),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_out_byte (result.out_byte),
    .result_has_byte (result.has_byte),
    .result_out_last (result.out_last)
);

@@ test/spr_result_checker.sv @@
// Checker: predicts the replaced byte stream and compares every result.
`timescale 1ns / 1ps
module spr_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spr_pkg::CFG_W-1:0]     cfg_data,
    spr_in_if                             text,
    spr_out_if                            result,
    output int                            mismatch_count,
    output int                            pending_results
);
    import spr_pkg::*;

    localparam int WIN_DEPTH = 8;

    logic [BYTE_W-1:0] win_bytes [WIN_DEPTH];
    int unsigned       win_fill;
    logic [CFG_W-1:0]  pat_bytes;
    logic [CFG_W-1:0]  rep_bytes;
    logic [LEN_W-1:0]  pat_len;
    logic [LEN_W-1:0]  rep_len;
    spr_result_t       expected_results [$];
    spr_result_t       step_results [$];
    spr_result_t       oldest;
    int                fail_cnt = 0;

    assign mismatch_count = fail_cnt;

    function automatic int unsigned capped_len(logic [LEN_W-1:0] len);
        return (len > LEN_CAP) ? LEN_CAP : int'(len);
    endfunction

    task automatic report_mismatch(string msg);
        fail_cnt++;
        $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    task automatic emit_byte(logic [BYTE_W-1:0] b, logic has);
        spr_result_t r;
        r.out_byte = b;
        r.has_byte = has;
        r.out_last = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic release_oldest();
        if (win_fill == 0)
            return;
        emit_byte(win_bytes[0], 1'b1);
        for (int i = 1; i < WIN_DEPTH; i++)
            win_bytes[i-1] = win_bytes[i];
        win_fill--;
    endtask

    function automatic bit window_is_pattern(int unsigned len);
        for (int i = 0; i < len; i++)
        begin
            if (win_bytes[i] !== pat_bytes[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out the results one accepted byte causes and queue them.
    task automatic predict_replace(logic [BYTE_W-1:0] b, logic last);
        int unsigned plen;
        int unsigned excess;
        int unsigned rlen;
        spr_result_t tail;
        plen = capped_len(pat_len);
        step_results.delete();
        if (win_fill < WIN_DEPTH)
        begin
            win_bytes[win_fill] = b;
            win_fill++;
        end
        if (win_fill > plen)
        begin
            // window longer than the pattern: no match test, drop up to two
            excess = win_fill - plen;
            release_oldest();
            if (excess > 1)
                release_oldest();
        end
        else if (win_fill == plen && plen > 0)
        begin
            if (window_is_pattern(plen))
            begin
                rlen = capped_len(rep_len);
                for (int i = 0; i < rlen; i++)
                    emit_byte(rep_bytes[8*i +: 8], 1'b1);
                win_fill = 0;
            end
            else
                release_oldest();
        end
        if (last)
        begin
            while (win_fill > 0)
                release_oldest();
            if (step_results.size() == 0)
                emit_byte('0, 1'b0);
            tail = step_results.pop_back();
            tail.out_last = 1'b1;
            step_results.push_back(tail);
        end
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes = '0;
            pat_len   = LEN_W'(1);
            rep_bytes = '0;
            rep_len   = '0;
            win_fill  = 0;
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN_BYTES:      pat_bytes = cfg_data;
                    CFG_PATTERN_LENGTH:     pat_len   = cfg_data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  rep_bytes = cfg_data;
                    CFG_REPLACEMENT_LENGTH: rep_len   = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (text.valid && text.ready)
                predict_replace(text.in_byte, text.in_last);
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result: byte 0x%0h has %0b last %0b",
                        result.out_byte, result.has_byte, result.out_last));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.out_byte !== oldest.out_byte)
                        report_mismatch($sformatf("out_byte: expected 0x%0h, got 0x%0h",
                            oldest.out_byte, result.out_byte));
                    if (result.has_byte !== oldest.has_byte)
                        report_mismatch($sformatf("has_byte: expected %0b, got %0b",
                            oldest.has_byte, result.has_byte));
                    if (result.out_last !== oldest.out_last)
                        report_mismatch($sformatf("out_last: expected %0b, got %0b",
                            oldest.out_last, result.out_last));
                end
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top: drives text and register writes into the find-and-replace block.
`timescale 1ns / 1ps
module tb_top;
    import spr_pkg::*;

    // Random part: three idling phases of about this many bytes each.
    localparam int PHASE_BYTES   = 120;
    // Cycles with no request moving on either channel before the run is abandoned.
    localparam int STALL_LIMIT   = 4000;
    // Extra cycles after the last expected result before touching registers.
    localparam int SETTLE_CYCLES = 6;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES   = 150;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    spr_in_if  text_ch ();
    spr_out_if result_ch ();

    int          mismatches;
    int          open_results;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          bytes_sent;
    int          stall_cycles = 0;
    int          hold_left    = 0;
    int          hold_reqs    = 0;
    int          hold_seen    = 0;
    logic [63:0] cur_pattern;
    int unsigned cur_plen;
    int          tx_pct [3] = '{32, 78, 0};
    int          rx_pct [3] = '{78, 32, 0};

    always #2 clk = ~clk;

    stream_pattern_replace #(
        .MAX_PATTERN     (8),
        .MAX_REPLACEMENT (8)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text      (text_ch),
        .result    (result_ch)
    );

    spr_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .text            (text_ch),
        .result          (result_ch),
        .mismatch_count  (mismatches),
        .pending_results (open_results)
    );

    // Result side: stall at random, or hold off for a long stretch on request
    // from the stimulus so that the block backs up into its text input.
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: restart the count on any accepted request, give up at the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offer one byte, idling first at the current rate; return at the falling
    // edge after the request is taken, with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.in_byte <= b;
        text_ch.in_last <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected result has come, then let the
    // block settle, since bytes held in the window produce nothing yet.
    task automatic drain_results();
        text_ch.valid <= 1'b0;
        @(negedge clk);
        while (open_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input spr_cfg_idx_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Write all four registers once the block is idle.
    task automatic load_setting(input logic [63:0] pb, input logic [3:0] pl,
                                input logic [63:0] rb, input logic [3:0] rl);
        drain_results();
        write_reg(CFG_PATTERN_BYTES, pb);
        write_reg(CFG_PATTERN_LENGTH, 64'(pl));
        write_reg(CFG_REPLACEMENT_BYTES, rb);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'(rl));
        cfg_we      <= 1'b0;
        cur_pattern  = pb;
        cur_plen     = (pl > LEN_CAP) ? LEN_CAP : pl;
    endtask

    // Pick a random setting, with extremes, zero length and oversized lengths
    // coming up often; patterns are mostly built from two symbols so that
    // self-overlapping and near-miss patterns appear.
    task automatic pick_setting();
        logic [63:0] pb;
        logic [63:0] rb;
        logic [3:0]  pl;
        logic [3:0]  rl;
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        int unsigned r;
        r = $urandom_range(9);
        case (r)
            0:       pl = 4'd1;
            1:       pl = 4'd8;
            2:       pl = 4'd0;
            3:       pl = 4'($urandom_range(9, 15));
            default: pl = 4'($urandom_range(1, 8));
        endcase
        r = $urandom_range(9);
        case (r)
            0:       rl = 4'd0;
            1:       rl = 4'd8;
            2:       rl = 4'($urandom_range(9, 15));
            default: rl = 4'($urandom_range(0, 8));
        endcase
        rb = {$urandom, $urandom};
        r  = $urandom_range(9);
        if (r < 5)
        begin
            sym_a = 8'($urandom);
            sym_b = 8'($urandom);
            for (int i = 0; i < 8; i++)
                pb[8*i +: 8] = $urandom_range(1) ? sym_a : sym_b;
        end
        else if (r < 7)
            pb = '1;
        else if (r < 8)
            pb = '0;
        else
            pb = {$urandom, $urandom};
        load_setting(pb, pl, rb, rl);
    endtask

    // Build one string from whole patterns, broken prefixes, pattern symbols
    // and random noise, and send it with the end flag on its final byte.
    task automatic send_string();
        logic [7:0]  text_bytes [$];
        int unsigned want_len;
        int unsigned r;
        int unsigned cut;
        want_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 18);
        while (text_bytes.size() < want_len)
        begin
            r = $urandom_range(99);
            if (cur_plen > 0 && r < 35)
            begin
                for (int i = 0; i < cur_plen; i++)
                    text_bytes.push_back(cur_pattern[8*i +: 8]);
            end
            else if (cur_plen > 1 && r < 55)
            begin
                cut = $urandom_range(1, cur_plen - 1);
                for (int i = 0; i < cut; i++)
                    text_bytes.push_back(cur_pattern[8*i +: 8]);
            end
            else if (cur_plen > 0 && r < 80)
                text_bytes.push_back(cur_pattern[8*$urandom_range(0, cur_plen - 1) +: 8]);
            else
                text_bytes.push_back(8'($urandom_range(255)));
        end
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    initial
    begin
        int phase_end;
        int strings_left;
        bit paused;
        cfg_we          = 1'b0;
        cfg_index       = CFG_PATTERN_BYTES;
        cfg_data        = '0;
        text_ch.valid   = 1'b0;
        text_ch.in_byte = '0;
        text_ch.in_last = 1'b0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        bytes_sent      = 0;
        cur_pattern     = '0;
        cur_plen        = 1;

        // Hold reset, then release it away from the rising edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: two-byte pattern of the extreme byte values, three-byte
        // replacement, then the remaining high/low bit patterns.
        load_setting(64'h0000_0000_0000_FF00, 4'd2, 64'h0000_0000_005A_5958, 4'd3);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);

        // Directed: empty replacement, so a string ending on a match leaves
        // nothing to emit and only the bare end marker comes out.
        load_setting(64'h0000_0000_0000_0061, 4'd1, '1, 4'd0);
        send_byte(8'h61, 1'b1);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b1);

        // Directed: zero pattern length passes bytes straight through.
        load_setting({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd8);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);

        // Directed: oversized lengths saturate to eight; a full match gives
        // the longest burst of results.
        load_setting(64'h0807_0605_0403_0201, 4'd15, 64'hF0E1_D2C3_B4A5_9687, 4'd12);
        for (int i = 1; i <= 8; i++)
            send_byte(8'(i), 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h09, 1'b0);

        // Directed: lower the pattern length while the window still holds
        // five bytes; it drains two per byte until it fits again.
        load_setting(64'h0807_0605_0403_0201, 4'd2, 64'hF0E1_D2C3_B4A5_9687, 4'd12);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);

        // Random: receiver-heavy stalling, then sender-heavy idling, then none.
        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct  = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            phase_end    = bytes_sent + PHASE_BYTES;
            strings_left = 0;
            paused       = 1'b0;
            while (bytes_sent < phase_end)
            begin
                if (strings_left == 0)
                begin
                    pick_setting();
                    strings_left = $urandom_range(2, 6);
                    // back the block up under a long receiver hold-off
                    if (p != 1 && bytes_sent + PHASE_BYTES / 2 > phase_end)
                        hold_reqs++;
                end
                // pause the sender once until every result is out
                if (p == 1 && !paused && bytes_sent + PHASE_BYTES / 2 >= phase_end)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                send_string();
                strings_left--;
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_if.sv
rtl/spr_cell.sv
rtl/spr_out_buf.sv
rtl/stream_pattern_replace.sv
rtl/spr_checker.sv
test/spr_result_checker.sv
test/tb_top.sv
